[rtl/five_axis_table_kinematics_unit_defines.svh]
// Assertion macros for the table kinematics unit
`ifndef FIVE_AXIS_TABLE_KINEMATICS_UNIT_DEFINES_SVH
`define FIVE_AXIS_TABLE_KINEMATICS_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define FATK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FATK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fatk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fatk_pkg
// Types, constants and tables for the five-axis table kinematics unit.
// ----------------------------------------------------------------------------
package fatk_pkg;

    typedef struct packed {
        logic               func;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] in_a;
        logic signed [31:0] in_b;
        logic               change_ok;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_a;
        logic signed [31:0] out_b;
        logic               space_changed;
        logic               tool_valid;
        logic signed [31:0] tool_x;
        logic signed [31:0] tool_y;
        logic signed [31:0] tool_z;
    } t_out;

    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_OFFSET = 1'b1;

    localparam int VAL_W  = 34;  // multiplier operand width
    localparam int TRIG_W = 32;  // trig factor width, Q2.30
    localparam int CRD_W  = 34;  // CORDIC datapath width
    localparam int ACC_W  = 50;  // sum width

    localparam logic [4:0] CORDIC_LAST = 5'd27;
    localparam logic [3:0] OP_LAST     = 4'd11;

    localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CRD_W-1:0] TRIG_ONE    = 34'sd1073741824;
    localparam logic signed [31:0] QUARTER  = 32'sd268435456;
    localparam logic signed [31:0] HALF     = 32'sd536870912;
    localparam logic signed [31:0] THREE_Q  = 32'sd805306368;
    localparam logic signed [31:0] FULL     = 32'sd1073741824;

    localparam logic [1:0] SRC_X = 2'd0;
    localparam logic [1:0] SRC_Y = 2'd1;
    localparam logic [1:0] SRC_D = 2'd2;
    localparam logic [1:0] SRC_T = 2'd3;

    localparam logic [1:0] COEF_SA = 2'd0;
    localparam logic [1:0] COEF_CA = 2'd1;
    localparam logic [1:0] COEF_SB = 2'd2;
    localparam logic [1:0] COEF_CB = 2'd3;

    localparam logic [1:0] DST_T  = 2'd0;
    localparam logic [1:0] DST_RX = 2'd1;
    localparam logic [1:0] DST_RY = 2'd2;
    localparam logic [1:0] DST_RZ = 2'd3;

    typedef struct packed {
        logic [1:0] src;
        logic [1:0] coef;
        logic [1:0] dst;
        logic       neg;
    } t_op;

    // arctangent of 2^-i in units of 2^-30 turn
    function automatic logic [27:0] atan_turns(input logic [4:0] i);
        case (i)
            5'd0:  atan_turns = 28'd134217728;
            5'd1:  atan_turns = 28'd79233352;
            5'd2:  atan_turns = 28'd41864727;
            5'd3:  atan_turns = 28'd21251189;
            5'd4:  atan_turns = 28'd10666833;
            5'd5:  atan_turns = 28'd5338616;
            5'd6:  atan_turns = 28'd2669960;
            5'd7:  atan_turns = 28'd1335061;
            5'd8:  atan_turns = 28'd667541;
            5'd9:  atan_turns = 28'd333772;
            5'd10: atan_turns = 28'd166886;
            5'd11: atan_turns = 28'd83443;
            5'd12: atan_turns = 28'd41722;
            5'd13: atan_turns = 28'd20861;
            5'd14: atan_turns = 28'd10430;
            5'd15: atan_turns = 28'd5215;
            5'd16: atan_turns = 28'd2608;
            5'd17: atan_turns = 28'd1304;
            5'd18: atan_turns = 28'd652;
            5'd19: atan_turns = 28'd326;
            5'd20: atan_turns = 28'd163;
            5'd21: atan_turns = 28'd81;
            5'd22: atan_turns = 28'd41;
            5'd23: atan_turns = 28'd20;
            5'd24: atan_turns = 28'd10;
            5'd25: atan_turns = 28'd5;
            5'd26: atan_turns = 28'd3;
            5'd27: atan_turns = 28'd1;
            default: atan_turns = 28'd0;
        endcase
    endfunction

    // product schedule: T is the scratch product for triple terms
    function automatic t_op op_entry(input logic inv, input logic [3:0] k);
        t_op o;
        o = '{src: SRC_X, coef: COEF_CB, dst: DST_RX, neg: 1'b0};
        if (!inv) begin
            case (k)
                4'd0:  o = '{src: SRC_X, coef: COEF_CB, dst: DST_RX, neg: 1'b0};
                4'd1:  o = '{src: SRC_Y, coef: COEF_SB, dst: DST_T,  neg: 1'b0};
                4'd2:  o = '{src: SRC_T, coef: COEF_SA, dst: DST_RX, neg: 1'b0};
                4'd3:  o = '{src: SRC_D, coef: COEF_SB, dst: DST_T,  neg: 1'b0};
                4'd4:  o = '{src: SRC_T, coef: COEF_CA, dst: DST_RX, neg: 1'b1};
                4'd5:  o = '{src: SRC_Y, coef: COEF_CA, dst: DST_RY, neg: 1'b0};
                4'd6:  o = '{src: SRC_D, coef: COEF_SA, dst: DST_RY, neg: 1'b0};
                4'd7:  o = '{src: SRC_X, coef: COEF_SB, dst: DST_RZ, neg: 1'b0};
                4'd8:  o = '{src: SRC_Y, coef: COEF_CB, dst: DST_T,  neg: 1'b0};
                4'd9:  o = '{src: SRC_T, coef: COEF_SA, dst: DST_RZ, neg: 1'b1};
                4'd10: o = '{src: SRC_D, coef: COEF_CB, dst: DST_T,  neg: 1'b0};
                4'd11: o = '{src: SRC_T, coef: COEF_CA, dst: DST_RZ, neg: 1'b0};
                default: o = '{src: SRC_X, coef: COEF_CB, dst: DST_T, neg: 1'b0};
            endcase
        end else begin
            case (k)
                4'd0:  o = '{src: SRC_X, coef: COEF_CB, dst: DST_RX, neg: 1'b0};
                4'd1:  o = '{src: SRC_D, coef: COEF_SB, dst: DST_RX, neg: 1'b0};
                4'd2:  o = '{src: SRC_X, coef: COEF_SB, dst: DST_T,  neg: 1'b0};
                4'd3:  o = '{src: SRC_T, coef: COEF_SA, dst: DST_RY, neg: 1'b0};
                4'd4:  o = '{src: SRC_Y, coef: COEF_CA, dst: DST_RY, neg: 1'b0};
                4'd5:  o = '{src: SRC_D, coef: COEF_CB, dst: DST_T,  neg: 1'b0};
                4'd6:  o = '{src: SRC_T, coef: COEF_SA, dst: DST_RY, neg: 1'b1};
                4'd7:  o = '{src: SRC_X, coef: COEF_SB, dst: DST_T,  neg: 1'b0};
                4'd8:  o = '{src: SRC_T, coef: COEF_CA, dst: DST_RZ, neg: 1'b1};
                4'd9:  o = '{src: SRC_Y, coef: COEF_SA, dst: DST_RZ, neg: 1'b0};
                4'd10: o = '{src: SRC_D, coef: COEF_CB, dst: DST_T,  neg: 1'b0};
                4'd11: o = '{src: SRC_T, coef: COEF_CA, dst: DST_RZ, neg: 1'b0};
                default: o = '{src: SRC_X, coef: COEF_CB, dst: DST_T, neg: 1'b0};
            endcase
        end
        return o;
    endfunction

endpackage

[rtl/fatk_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fatk_mul
// Bit-serial signed multiplier with Q2.30 rounding: (v*c + 2^29) >>> 30.
// ----------------------------------------------------------------------------
module fatk_mul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [fatk_pkg::VAL_W-1:0]     i_v,
    input  logic signed [fatk_pkg::TRIG_W-1:0]    i_c,
    output logic                                  o_done,
    output logic signed [fatk_pkg::VAL_W-1:0]     o_p
);
    localparam int PW = fatk_pkg::VAL_W + fatk_pkg::TRIG_W;
    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_RUN  = 2'd1;
    localparam logic [1:0] M_RND  = 2'd2;

    logic [1:0]                         r_state;
    logic [4:0]                         r_cnt;
    logic signed [PW-1:0]               r_mc;
    logic [fatk_pkg::TRIG_W-1:0]        r_mr;
    logic signed [PW-1:0]               r_acc;
    logic signed [PW-1:0]               n_sum;
    logic                               r_done;
    logic signed [fatk_pkg::VAL_W-1:0]  r_p;

    assign n_sum = r_acc + (PW'(1) <<< 29);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_mc    <= PW'(i_v);
                        r_mr    <= i_c;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= M_RUN;
                    end
                end
                M_RUN: begin
                    // sign bit of the multiplier carries negative weight
                    if (r_mr[0]) begin
                        r_acc <= (r_cnt == 5'd31) ? r_acc - r_mc : r_acc + r_mc;
                    end
                    r_mc  <= r_mc <<< 1;
                    r_mr  <= r_mr >> 1;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= M_RND;
                    end
                end
                M_RND: begin
                    r_p     <= n_sum[30 +: fatk_pkg::VAL_W];
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule

[rtl/fatk_sincos.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fatk_sincos
// Degree angle to sine/cosine: serial reduction mod 360, serial phase
// division, then a 28-step CORDIC rotation.
// ----------------------------------------------------------------------------
module fatk_sincos #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [31:0]                   i_ang,
    output logic                                 o_done,
    output logic signed [fatk_pkg::TRIG_W-1:0]   o_sin,
    output logic signed [fatk_pkg::TRIG_W-1:0]   o_cos
);
    localparam int MW = FRAC_BITS + 9;
    localparam longint unsigned MOD_L = 64'd360 << FRAC_BITS;
    localparam longint unsigned OFS_L = (64'd1 << 31) % MOD_L;
    localparam logic [MW:0] MOD_M = (MW+1)'(MOD_L);
    localparam logic [MW:0] OFS_C = (MW+1)'(OFS_L);
    localparam int CW = fatk_pkg::CRD_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_FIX  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_QUAD = 3'd4;
    localparam logic [2:0] S_CORD = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]           r_state;
    logic [4:0]           r_cnt;
    logic [31:0]          r_u;
    logic [MW:0]          r_rem;
    logic [29:0]          r_q;
    logic signed [31:0]   r_p;
    logic                 r_neg;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic                 r_done;
    logic signed [fatk_pkg::TRIG_W-1:0] r_sin;
    logic signed [fatk_pkg::TRIG_W-1:0] r_cos;

    logic [MW:0]          n_mod_t;
    logic [MW:0]          n_div_t;
    logic signed [31:0]   n_pq;
    logic signed [CW-1:0] n_xs;
    logic signed [CW-1:0] n_ys;
    logic signed [31:0]   n_at;
    logic signed [CW-1:0] n_xf;
    logic signed [CW-1:0] n_yf;

    assign n_mod_t = {r_rem[MW-1:0], r_u[31]};
    assign n_div_t = {r_rem[MW-1:0], 1'b0};
    assign n_pq    = {2'b00, r_q};
    assign n_xs    = r_x >>> r_cnt;
    assign n_ys    = r_y >>> r_cnt;
    assign n_at    = {4'b0000, fatk_pkg::atan_turns(r_cnt)};
    assign n_xf    = r_neg ? -r_x : r_x;
    assign n_yf    = r_neg ? -r_y : r_y;

    function automatic logic signed [fatk_pkg::TRIG_W-1:0] clamp(
        input logic signed [CW-1:0] v);
        if (v > fatk_pkg::TRIG_ONE) begin
            return fatk_pkg::TRIG_W'(fatk_pkg::TRIG_ONE);
        end else if (v < -fatk_pkg::TRIG_ONE) begin
            return fatk_pkg::TRIG_W'(-fatk_pkg::TRIG_ONE);
        end
        return fatk_pkg::TRIG_W'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        // bias by 2^31 so the dividend is unsigned
                        r_u     <= {~i_ang[31], i_ang[30:0]};
                        r_rem   <= '0;
                        r_cnt   <= 5'd31;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_rem <= (n_mod_t >= MOD_M) ? n_mod_t - MOD_M : n_mod_t;
                    r_u   <= r_u << 1;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    // remove the bias again, modulo a full turn
                    r_rem   <= (r_rem >= OFS_C) ? r_rem - OFS_C : r_rem + MOD_M - OFS_C;
                    r_cnt   <= 5'd29;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= (n_div_t >= MOD_M) ? n_div_t - MOD_M : n_div_t;
                    r_q   <= {r_q[28:0], n_div_t >= MOD_M};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_state <= S_QUAD;
                    end
                end
                S_QUAD: begin
                    r_neg <= 1'b0;
                    if (n_pq >= fatk_pkg::THREE_Q) begin
                        r_p <= n_pq - fatk_pkg::FULL;
                    end else if (n_pq > fatk_pkg::QUARTER) begin
                        r_p   <= n_pq - fatk_pkg::HALF;
                        r_neg <= 1'b1;
                    end else begin
                        r_p <= n_pq;
                    end
                    r_x     <= fatk_pkg::CORDIC_GAIN;
                    r_y     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (!r_p[31]) begin
                        r_x <= r_x - n_ys;
                        r_y <= r_y + n_xs;
                        r_p <= r_p - n_at;
                    end else begin
                        r_x <= r_x + n_ys;
                        r_y <= r_y - n_xs;
                        r_p <= r_p + n_at;
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == fatk_pkg::CORDIC_LAST) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_cos   <= clamp(n_xf);
                    r_sin   <= clamp(n_yf);
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;
endmodule

[rtl/five_axis_table_kinematics_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_axis_table_kinematics_unit
// A/B tilting-rotary table kinematics, forward and inverse, Q16.16.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       input      i_in_valid/o_in_stall  i_in  (fatk_pkg::t_in)
// out      output     o_out_valid/i_out_stall o_out (fatk_pkg::t_out)
// cfg      input      i_cfg_we               i_cfg_idx, i_cfg_data
//
// One transaction at a time. Pass-through: the input is registered, then the result.
// Five-axis: two sine/cosine units run side by side (32 reduction steps, a
// fix-up, 30 division steps, a quadrant step, 28 CORDIC steps), then 12
// products are formed in turn on one bit-serial multiplier.
// Synchronous active-low reset; the input stalls until the result is taken,
// and output stall lengthens the transaction.
// ----------------------------------------------------------------------------
`include "five_axis_table_kinematics_unit_defines.svh"

module five_axis_table_kinematics_unit #(
    parameter int POS_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  fatk_pkg::t_in     i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fatk_pkg::t_out    o_out,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [31:0]       i_cfg_data
);
    localparam int AW = fatk_pkg::ACC_W;
    localparam int VW = fatk_pkg::VAL_W;
    localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_TRIG  = 3'd1;
    localparam logic [2:0] T_MUL   = 3'd2;
    localparam logic [2:0] T_MWAIT = 3'd3;
    localparam logic [2:0] T_ZADD  = 3'd4;
    localparam logic [2:0] T_FIN   = 3'd5;
    localparam logic [2:0] T_OUT   = 3'd6;

    logic               r_reg_en;
    logic signed [31:0] r_reg_off;
    logic               r_act_en;
    logic signed [31:0] r_act_off;
    logic               r_flag;

    logic [2:0]          r_state;
    logic [3:0]          r_k;
    fatk_pkg::t_in       r_in;
    logic                r_tool;
    logic                r_trig_start;
    logic signed [VW-1:0] r_d;
    logic signed [VW-1:0] r_t;
    logic signed [AW-1:0] r_rx;
    logic signed [AW-1:0] r_ry;
    logic signed [AW-1:0] r_rz;
    logic                r_out_valid;
    fatk_pkg::t_out      r_out;

    logic                n_accept;
    logic                n_en;
    logic signed [31:0]  n_off;
    logic                n_diff;
    fatk_pkg::t_op       n_op;
    logic signed [VW-1:0] n_v;
    logic signed [fatk_pkg::TRIG_W-1:0] n_c;
    logic signed [AW-1:0] n_term;
    logic signed [AW-1:0] n_tz;

    logic a_done, b_done, m_done;
    logic signed [fatk_pkg::TRIG_W-1:0] sa, ca, sb, cb;
    logic signed [VW-1:0] m_p;

    function automatic logic [31:0] sat32(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] s;
        s = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
        return s[31:0];
    endfunction

    assign n_accept = i_in_valid && !o_in_stall;
    assign n_diff   = (r_reg_en != r_act_en) || (r_reg_off != r_act_off);
    assign n_en     = (!i_in.func && i_in.change_ok) ? r_reg_en : r_act_en;
    assign n_off    = (!i_in.func && i_in.change_ok) ? r_reg_off : r_act_off;

    assign n_op = fatk_pkg::op_entry(r_in.func, r_k);

    always_comb begin
        case (n_op.src)
            fatk_pkg::SRC_X: n_v = VW'(r_in.in_x);
            fatk_pkg::SRC_Y: n_v = VW'(r_in.in_y);
            fatk_pkg::SRC_D: n_v = r_d;
            fatk_pkg::SRC_T: n_v = r_t;
            default:         n_v = r_t;
        endcase
        case (n_op.coef)
            fatk_pkg::COEF_SA: n_c = sa;
            fatk_pkg::COEF_CA: n_c = ca;
            fatk_pkg::COEF_SB: n_c = sb;
            fatk_pkg::COEF_CB: n_c = cb;
            default:           n_c = cb;
        endcase
    end

    assign n_term = n_op.neg ? -AW'(m_p) : AW'(m_p);
    assign n_tz   = r_rz - AW'(r_act_off);

    fatk_sincos #(.FRAC_BITS(FRAC_BITS)) u_trig_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_trig_start),
        .i_ang(r_in.in_a), .o_done(a_done), .o_sin(sa), .o_cos(ca)
    );

    fatk_sincos #(.FRAC_BITS(FRAC_BITS)) u_trig_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_trig_start),
        .i_ang(r_in.in_b), .o_done(b_done), .o_sin(sb), .o_cos(cb)
    );

    fatk_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == T_MUL),
        .i_v(n_v), .i_c(n_c), .o_done(m_done), .o_p(m_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_en     <= 1'b0;
            r_reg_off    <= '0;
            r_act_en     <= 1'b0;
            r_act_off    <= '0;
            r_flag       <= 1'b0;
            r_state      <= T_IDLE;
            r_k          <= '0;
            r_tool       <= 1'b0;
            r_trig_start <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_trig_start <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fatk_pkg::CFG_ENABLE: r_reg_en  <= i_cfg_data[0];
                    fatk_pkg::CFG_OFFSET: r_reg_off <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                T_IDLE: begin
                    if (n_accept) begin
                        r_in   <= i_in;
                        r_tool <= !i_in.func && i_in.change_ok;
                        if (!i_in.func) begin
                            if (i_in.change_ok) begin
                                r_act_en  <= r_reg_en;
                                r_act_off <= r_reg_off;
                                r_flag    <= 1'b0;
                            end else if (n_diff) begin
                                r_flag <= 1'b1;
                            end
                        end
                        r_rx <= AW'(i_in.in_x);
                        r_ry <= AW'(i_in.in_y);
                        r_rz <= AW'(i_in.in_z);
                        r_d  <= VW'(i_in.in_z) - VW'(n_off);
                        if (n_en) begin
                            r_trig_start <= 1'b1;
                            r_state      <= T_TRIG;
                        end else begin
                            r_state <= T_FIN;
                        end
                    end
                end
                T_TRIG: begin
                    if (a_done && b_done) begin
                        r_rx    <= '0;
                        r_ry    <= '0;
                        r_rz    <= '0;
                        r_k     <= '0;
                        r_state <= T_MUL;
                    end
                end
                T_MUL: r_state <= T_MWAIT;
                T_MWAIT: begin
                    if (m_done) begin
                        case (n_op.dst)
                            fatk_pkg::DST_T:  r_t  <= m_p;
                            fatk_pkg::DST_RX: r_rx <= r_rx + n_term;
                            fatk_pkg::DST_RY: r_ry <= r_ry + n_term;
                            fatk_pkg::DST_RZ: r_rz <= r_rz + n_term;
                            default: ;
                        endcase
                        if (r_k == fatk_pkg::OP_LAST) begin
                            r_state <= T_ZADD;
                        end else begin
                            r_k     <= r_k + 4'd1;
                            r_state <= T_MUL;
                        end
                    end
                end
                T_ZADD: begin
                    r_rz    <= r_rz + AW'(r_act_off);
                    r_state <= T_FIN;
                end
                T_FIN: begin
                    r_out.out_x         <= sat32(r_rx);
                    r_out.out_y         <= sat32(r_ry);
                    r_out.out_z         <= sat32(r_rz);
                    r_out.out_a         <= r_in.in_a;
                    r_out.out_b         <= r_in.in_b;
                    r_out.space_changed <= r_flag;
                    r_out.tool_valid    <= r_tool;
                    r_out.tool_x        <= r_tool ? sat32(r_rx) : 32'd0;
                    r_out.tool_y        <= r_tool ? sat32(r_ry) : 32'd0;
                    r_out.tool_z        <= r_tool ? sat32(n_tz) : 32'd0;
                    r_out_valid         <= 1'b1;
                    r_state             <= T_OUT;
                end
                T_OUT: begin
                    // hold the result until the consumer takes it
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        r_state     <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != T_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `FATK_ASSERT_NOW(a_out_blocks_in, o_out_valid, o_in_stall, "input open while result pending")
    `FATK_ASSERT_NEXT(a_accept_busy, i_in_valid && !o_in_stall, o_in_stall && !o_out_valid, "accept did not start work")
    `FATK_ASSERT_NOW(a_tool_zero, o_out_valid && !o_out.tool_valid, o_out.tool_x == 32'd0 && o_out.tool_z == 32'd0, "tool pose without tool_valid")
    `FATK_ASSERT_NEXT(a_out_drain, o_out_valid && !i_out_stall, !o_out_valid && !o_in_stall, "result not retired")
endmodule
